FILE: design/lwbc_pkg.sv
// Shared types, codes and helper functions for the layer window blend compositor.
package lwbc_pkg;

   localparam int QUEUE_DEPTH_DEF = 4;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 64;

   localparam logic [CSR_INDEX_W-1:0] CSR_WINDOW_RECTS       = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_WINDOW_LAYER_MASKS = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_WINDOW_ENABLES     = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_BLEND_SELECT       = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_BLEND_COEFFS       = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_BG_PRIORITIES      = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_BACKDROP_COLOR     = 3'd6;

   // Layer codes, also bit positions in the target masks
   localparam logic [2:0] LAYER_PLANE0   = 3'd0;
   localparam logic [2:0] LAYER_PLANE1   = 3'd1;
   localparam logic [2:0] LAYER_PLANE2   = 3'd2;
   localparam logic [2:0] LAYER_PLANE3   = 3'd3;
   localparam logic [2:0] LAYER_SPRITE   = 3'd4;
   localparam logic [2:0] LAYER_BACKDROP = 3'd5;

   // No layer found yet: worse than any two-bit priority
   localparam logic [2:0] PRIO_NONE = 3'd4;

   localparam logic [1:0] MODE_NONE   = 2'd0;
   localparam logic [1:0] MODE_ALPHA  = 2'd1;
   localparam logic [1:0] MODE_BRIGHT = 2'd2;
   localparam logic [1:0] MODE_DARK   = 2'd3;

   typedef enum logic [1:0] {
      OP_NONE   = 2'd0,
      OP_ALPHA  = 2'd1,
      OP_BRIGHT = 2'd2,
      OP_DARK   = 2'd3
   } op_type;

   typedef struct packed {
      logic [63:0] window_rects;
      logic [31:0] window_layer_masks;
      logic [2:0]  window_enables;
      logic [13:0] blend_select;
      logic [14:0] blend_coeffs;
      logic [7:0]  bg_priorities;
      logic [14:0] backdrop_color;
   } cfg_type;

   typedef struct packed {
      logic [23:0] top_color;
      logic [23:0] bot_color;
      op_type      op;
   } item_type;

   function automatic logic [7:0] expand5(input logic [4:0] v);
      logic [13:0] prod;
      prod = 14'(v) * 14'd527 + 14'd23;
      return prod[13:6];
   endfunction

   // Span test with wraparound when the low edge lies past the high edge
   function automatic logic in_span(input logic [7:0] p, input logic [7:0] lo,
                                    input logic [7:0] hi);
      if (lo > hi) begin
         return (p < hi) || (p >= lo);
      end
      return (p >= lo) && (p < hi);
   endfunction

endpackage

FILE: design/lwbc_front.sv
// Front end: window selection, layer priority resolution and blend classification.
module lwbc_front (
   input  lwbc_pkg::cfg_type  cfg,
   input  logic [7:0]         pixel_x,
   input  logic [7:0]         line_y,
   input  logic [23:0]        bg0_color,
   input  logic [23:0]        bg1_color,
   input  logic [23:0]        bg2_color,
   input  logic [23:0]        bg3_color,
   input  logic [3:0]         bg_present,
   input  logic [23:0]        sprite_color,
   input  logic [7:0]         sprite_flags,
   output lwbc_pkg::item_type item
);
   import lwbc_pkg::*;

   logic [23:0] backdrop_rgb;

   assign backdrop_rgb = {expand5(cfg.backdrop_color[14:10]),
                          expand5(cfg.backdrop_color[9:5]),
                          expand5(cfg.backdrop_color[4:0])};

   function automatic logic [23:0] layer_color(input logic [2:0] layer,
                                               input logic [23:0] c0,
                                               input logic [23:0] c1,
                                               input logic [23:0] c2,
                                               input logic [23:0] c3,
                                               input logic [23:0] cs,
                                               input logic [23:0] cb);
      logic [23:0] c;
      case (layer)
         LAYER_PLANE0: c = c0;
         LAYER_PLANE1: c = c1;
         LAYER_PLANE2: c = c2;
         LAYER_PLANE3: c = c3;
         LAYER_SPRITE: c = cs;
         default:      c = cb;
      endcase
      return c;
   endfunction

   always_comb begin
      logic       in_win0;
      logic       in_win1;
      logic [7:0] win;
      logic [3:0] elig;
      logic [3:0] key [4];
      logic [1:0] rank [4];
      logic [2:0] top;
      logic [2:0] bot;
      logic [2:0] tp;
      logic [2:0] bp;
      logic [2:0] sp;
      logic       alpha_obj;
      logic [1:0] mode;
      logic [5:0] tmask;
      logic [5:0] bmask;
      logic       top_ok;
      logic       bot_ok;

      in_win0 = cfg.window_enables[0]
                && in_span(pixel_x, cfg.window_rects[15:8], cfg.window_rects[7:0])
                && in_span(line_y, cfg.window_rects[31:24], cfg.window_rects[23:16]);
      in_win1 = cfg.window_enables[1]
                && in_span(pixel_x, cfg.window_rects[47:40], cfg.window_rects[39:32])
                && in_span(line_y, cfg.window_rects[63:56], cfg.window_rects[55:48]);

      if (cfg.window_enables == 3'd0) begin
         win = 8'hFF;
      end else if (in_win0) begin
         win = cfg.window_layer_masks[7:0];
      end else if (in_win1) begin
         win = cfg.window_layer_masks[15:8];
      end else if (cfg.window_enables[2] && sprite_flags[6]) begin
         win = cfg.window_layer_masks[31:24];
      end else begin
         win = cfg.window_layer_masks[23:16];
      end

      // Rank each visible background by {priority, index}; lower key wins
      elig = win[3:0] & bg_present;
      for (int j = 0; j < 4; j++) begin
         key[j] = {cfg.bg_priorities[2*j +: 2], 2'(j)};
      end
      for (int j = 0; j < 4; j++) begin
         rank[j] = 2'd0;
         for (int k = 0; k < 4; k++) begin
            if (k != j && elig[k] && key[k] < key[j]) begin
               rank[j] = rank[j] + 2'd1;
            end
         end
      end

      top = LAYER_BACKDROP;
      bot = LAYER_BACKDROP;
      tp  = PRIO_NONE;
      bp  = PRIO_NONE;
      for (int j = 0; j < 4; j++) begin
         if (elig[j] && rank[j] == 2'd0) begin
            top = 3'(j);
            tp  = {1'b0, cfg.bg_priorities[2*j +: 2]};
         end
         if (elig[j] && rank[j] == 2'd1) begin
            bot = 3'(j);
            bp  = {1'b0, cfg.bg_priorities[2*j +: 2]};
         end
      end

      // Sprite wins ties against backgrounds
      alpha_obj = 1'b0;
      sp = {1'b0, sprite_flags[2:1]};
      if (win[4] && sprite_flags[7]) begin
         if (sp <= tp) begin
            bot       = top;
            top       = LAYER_SPRITE;
            alpha_obj = sprite_flags[0];
         end else if (sp <= bp) begin
            bot = LAYER_SPRITE;
         end
      end

      mode   = win[5] ? cfg.blend_select[7:6] : MODE_NONE;
      tmask  = cfg.blend_select[5:0] | {1'b0, alpha_obj, 4'b0000};
      bmask  = cfg.blend_select[13:8];
      top_ok = tmask[top];
      bot_ok = bmask[bot];
      // Semi-transparent sprite over a second target forces alpha
      if (alpha_obj && bot_ok) begin
         mode = MODE_ALPHA;
      end

      if (mode == MODE_ALPHA && top_ok && bot_ok) begin
         item.op = OP_ALPHA;
      end else if (mode == MODE_BRIGHT && top_ok) begin
         item.op = OP_BRIGHT;
      end else if (mode == MODE_DARK && top_ok) begin
         item.op = OP_DARK;
      end else begin
         item.op = OP_NONE;
      end

      item.top_color = layer_color(top, bg0_color, bg1_color, bg2_color, bg3_color,
                                   sprite_color, backdrop_rgb);
      item.bot_color = layer_color(bot, bg0_color, bg1_color, bg2_color, bg3_color,
                                   sprite_color, backdrop_rgb);
   end

endmodule

FILE: design/lwbc_queue.sv
// Short queue of classified pixels between the front end and the blend unit.
module lwbc_queue #(
   parameter int DEPTH = lwbc_pkg::QUEUE_DEPTH_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  lwbc_pkg::item_type push_item,
   output logic               full,
   input  logic               pop,
   output lwbc_pkg::item_type head_item,
   output logic               empty
);
   import lwbc_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

   item_type         entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_in;
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   logic             do_push;
   logic             do_pop;

   assign full      = (count_ff == CNT_W'(DEPTH));
   assign empty     = (count_ff == '0);
   assign do_push   = push && !full;
   assign do_pop    = pop && !empty;
   assign head_item = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

FILE: design/lwbc_back.sv
// Back end: per-channel alpha, brighten and darken with saturation, and the result register.
module lwbc_back (
   input  logic               clock,
   input  logic               reset,
   input  logic [14:0]        blend_coeffs,
   input  logic               q_empty,
   input  lwbc_pkg::item_type q_item,
   output logic               q_pop,
   output logic               rsp_empty,
   input  logic               rsp_pop,
   output logic [23:0]        rsp_out_color
);
   import lwbc_pkg::*;

   logic        out_valid_ff;
   logic        out_valid_in;
   logic [23:0] out_color_ff;
   logic [23:0] out_color_in;
   logic        take;

   // Advance whenever the result register is free or being drained
   assign take          = !q_empty && (!out_valid_ff || rsp_pop);
   assign q_pop         = take;
   assign rsp_empty     = !out_valid_ff;
   assign rsp_out_color = out_color_ff;

   always_comb begin
      logic [4:0]  eva;
      logic [4:0]  evb;
      logic [4:0]  evy;
      logic [7:0]  t;
      logic [7:0]  b;
      logic [13:0] alpha_sum;
      logic [12:0] prod;
      logic [9:0]  bright_sum;
      logic [8:0]  dark_sub;
      logic [7:0]  r;

      eva = blend_coeffs[4:0];
      evb = blend_coeffs[9:5];
      evy = blend_coeffs[14:10];
      out_color_in = '0;
      for (int ch = 0; ch < 3; ch++) begin
         t = q_item.top_color[8*ch +: 8];
         b = q_item.bot_color[8*ch +: 8];
         alpha_sum  = 14'(t) * 14'(eva) + 14'(b) * 14'(evb);
         prod       = 13'(8'hFF - t) * 13'(evy);
         bright_sum = 10'(t) + 10'(prod[12:4]);
         prod       = 13'(t) * 13'(evy);
         dark_sub   = prod[12:4];
         case (q_item.op)
            OP_ALPHA: begin
               r = (alpha_sum[13:4] > 10'd255) ? 8'hFF : alpha_sum[11:4];
            end
            OP_BRIGHT: begin
               r = (bright_sum > 10'd255) ? 8'hFF : bright_sum[7:0];
            end
            OP_DARK: begin
               r = (dark_sub > {1'b0, t}) ? 8'h00 : t - dark_sub[7:0];
            end
            default: begin
               r = t;
            end
         endcase
         out_color_in[8*ch +: 8] = r;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (take) begin
         out_valid_in = 1'b1;
      end else if (rsp_pop) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         out_color_ff <= out_color_in;
      end
   end

endmodule

FILE: design/layer_window_blend_compositor.sv
// Top level: control registers, front end, classification queue and blend back end.
// An accepted request is written into the queue, then registered in the result register once that is free.
// Throughput: one pixel per cycle; the queue and the result register let each side stall.
// The request side reports full once QUEUE_DEPTH classified pixels wait for the blend unit.
// Reset (synchronous, active high) empties the queue and result register and zeroes
// every control register.
module layer_window_blend_compositor #(
   parameter int QUEUE_DEPTH = lwbc_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_push,
   output logic                               req_full,
   input  logic [7:0]                         req_pixel_x,
   input  logic [7:0]                         req_line_y,
   input  logic [23:0]                        req_bg0_color,
   input  logic [23:0]                        req_bg1_color,
   input  logic [23:0]                        req_bg2_color,
   input  logic [23:0]                        req_bg3_color,
   input  logic [3:0]                         req_bg_present,
   input  logic [23:0]                        req_sprite_color,
   input  logic [7:0]                         req_sprite_flags,
   output logic                               rsp_empty,
   input  logic                               rsp_pop,
   output logic [23:0]                        rsp_out_color,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [lwbc_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [lwbc_pkg::CSR_DATA_W-1:0]    csr_data
);
   import lwbc_pkg::*;

   cfg_type  cfg_ff;
   cfg_type  cfg_in;
   item_type front_item;
   item_type head_item;
   logic     q_empty;
   logic     q_pop;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_WINDOW_RECTS:       cfg_in.window_rects       = csr_data;
            CSR_WINDOW_LAYER_MASKS: cfg_in.window_layer_masks = csr_data[31:0];
            CSR_WINDOW_ENABLES:     cfg_in.window_enables     = csr_data[2:0];
            CSR_BLEND_SELECT:       cfg_in.blend_select       = csr_data[13:0];
            CSR_BLEND_COEFFS:       cfg_in.blend_coeffs       = csr_data[14:0];
            CSR_BG_PRIORITIES:      cfg_in.bg_priorities      = csr_data[7:0];
            CSR_BACKDROP_COLOR:     cfg_in.backdrop_color     = csr_data[14:0];
            default:                cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   lwbc_front u_front (
      .cfg          (cfg_ff),
      .pixel_x      (req_pixel_x),
      .line_y       (req_line_y),
      .bg0_color    (req_bg0_color),
      .bg1_color    (req_bg1_color),
      .bg2_color    (req_bg2_color),
      .bg3_color    (req_bg3_color),
      .bg_present   (req_bg_present),
      .sprite_color (req_sprite_color),
      .sprite_flags (req_sprite_flags),
      .item         (front_item)
   );

   lwbc_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_push),
      .push_item (front_item),
      .full      (req_full),
      .pop       (q_pop),
      .head_item (head_item),
      .empty     (q_empty)
   );

   lwbc_back u_back (
      .clock         (clock),
      .reset         (reset),
      .blend_coeffs  (cfg_ff.blend_coeffs),
      .q_empty       (q_empty),
      .q_item        (head_item),
      .q_pop         (q_pop),
      .rsp_empty     (rsp_empty),
      .rsp_pop       (rsp_pop),
      .rsp_out_color (rsp_out_color)
   );

endmodule

FILE: dv/tb_top.sv
// Self-checking testbench for the layer window blend compositor: directed and random pixels.
`timescale 1ns / 100ps

module tb_top;
   import lwbc_pkg::*;

   typedef struct packed {
      logic [7:0]  x;
      logic [7:0]  y;
      logic [23:0] bg0;
      logic [23:0] bg1;
      logic [23:0] bg2;
      logic [23:0] bg3;
      logic [3:0]  present;
      logic [23:0] spr;
      logic [7:0]  flags;
   } pixel_req_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_push = 1'b0;
   logic        req_full;
   logic [7:0]  req_pixel_x = '0;
   logic [7:0]  req_line_y = '0;
   logic [23:0] req_bg0_color = '0;
   logic [23:0] req_bg1_color = '0;
   logic [23:0] req_bg2_color = '0;
   logic [23:0] req_bg3_color = '0;
   logic [3:0]  req_bg_present = '0;
   logic [23:0] req_sprite_color = '0;
   logic [7:0]  req_sprite_flags = '0;
   logic        rsp_empty;
   logic        rsp_pop = 1'b0;
   logic [23:0] rsp_out_color;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_data = '0;

   cfg_type       model_cfg = '0;
   pixel_req_type pending_pixels[$];
   logic [23:0]   expected_colors[$];
   int          error_count = 0;
   int          pixels_sent = 0;
   int          colors_checked = 0;
   int          settings_loaded = 0;
   int          in_gap_pct = 0;
   int          out_gap_pct = 0;
   bit          calm = 1'b0;
   int          in_hold = 0;
   int          out_hold = 0;

   layer_window_blend_compositor dut (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_pixel_x      (req_pixel_x),
      .req_line_y       (req_line_y),
      .req_bg0_color    (req_bg0_color),
      .req_bg1_color    (req_bg1_color),
      .req_bg2_color    (req_bg2_color),
      .req_bg3_color    (req_bg3_color),
      .req_bg_present   (req_bg_present),
      .req_sprite_color (req_sprite_color),
      .req_sprite_flags (req_sprite_flags),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_out_color    (rsp_out_color),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   always #1 clock = ~clock;

   // ---------------------------------------------------------------- predictor
   function automatic int widen5(input logic [4:0] v);
      return (int'(v) * 527 + 23) >> 6;
   endfunction

   function automatic bit span_hit(input logic [7:0] p, input logic [7:0] lo,
                                   input logic [7:0] hi);
      if (lo <= hi) begin
         return (p >= lo) && (p < hi);
      end
      return (p < hi) || (p >= lo);
   endfunction

   function automatic bit rect_hit(input logic [7:0] px, input logic [7:0] py,
                                   input logic [15:0] h, input logic [15:0] v);
      return span_hit(px, h[15:8], h[7:0]) && span_hit(py, v[15:8], v[7:0]);
   endfunction

   function automatic logic [23:0] composite_pixel(input cfg_type c, input pixel_req_type px);
      logic [23:0] col [0:5];
      logic [7:0]  win;
      logic [5:0]  tmask;
      logic [5:0]  bmask;
      logic        alpha_obj;
      logic        top_ok;
      logic        bot_ok;
      op_type      op;
      logic [23:0] res;
      int          top, bot, tp, bp, found, sp, t, b, r, eva, evb, evy;

      col[0] = px.bg0;
      col[1] = px.bg1;
      col[2] = px.bg2;
      col[3] = px.bg3;
      col[4] = px.spr;
      col[5] = {8'(widen5(c.backdrop_color[14:10])), 8'(widen5(c.backdrop_color[9:5])),
                8'(widen5(c.backdrop_color[4:0]))};

      if (c.window_enables == 3'd0) begin
         win = 8'hFF;
      end else if (c.window_enables[0] &&
                   rect_hit(px.x, px.y, c.window_rects[15:0], c.window_rects[31:16])) begin
         win = c.window_layer_masks[7:0];
      end else if (c.window_enables[1] &&
                   rect_hit(px.x, px.y, c.window_rects[47:32], c.window_rects[63:48])) begin
         win = c.window_layer_masks[15:8];
      end else if (c.window_enables[2] && px.flags[6]) begin
         win = c.window_layer_masks[31:24];
      end else begin
         win = c.window_layer_masks[23:16];
      end

      top = int'(LAYER_BACKDROP);
      bot = int'(LAYER_BACKDROP);
      tp = int'(PRIO_NONE);
      bp = int'(PRIO_NONE);
      found = 0;
      alpha_obj = 1'b0;
      for (int p = 0; p < 4; p++) begin
         for (int j = 0; j < 4; j++) begin
            if (found < 2 && int'(c.bg_priorities[2*j +: 2]) == p && win[j] && px.present[j]) begin
               if (found == 0) begin
                  top = j;
                  tp = p;
               end else begin
                  bot = j;
                  bp = p;
               end
               found++;
            end
         end
      end

      // sprite beats a background of equal priority
      if (win[4] && px.flags[7]) begin
         sp = int'(px.flags[2:1]);
         if (sp <= tp) begin
            bot = top;
            bp = tp;
            top = int'(LAYER_SPRITE);
            tp = sp;
            alpha_obj = px.flags[0];
         end else if (sp <= bp) begin
            bot = int'(LAYER_SPRITE);
            bp = sp;
         end
      end

      op = win[5] ? op_type'(c.blend_select[7:6]) : OP_NONE;
      tmask = c.blend_select[5:0] | {1'b0, alpha_obj, 4'b0000};
      bmask = c.blend_select[13:8];
      top_ok = tmask[top];
      bot_ok = bmask[bot];
      // semi-transparent sprite on top forces alpha, even with effects masked off
      if (alpha_obj && bot_ok) begin
         op = OP_ALPHA;
      end

      eva = int'(c.blend_coeffs[4:0]);
      evb = int'(c.blend_coeffs[9:5]);
      evy = int'(c.blend_coeffs[14:10]);
      res = '0;
      for (int ch = 0; ch < 3; ch++) begin
         t = int'(col[top][8*ch +: 8]);
         b = int'(col[bot][8*ch +: 8]);
         r = t;
         case (op)
            OP_ALPHA: begin
               if (top_ok && bot_ok) r = (t * eva + b * evb) >>> 4;
            end
            OP_BRIGHT: begin
               if (top_ok) r = t + (((255 - t) * evy) >>> 4);
            end
            OP_DARK: begin
               if (top_ok) r = t - ((t * evy) >>> 4);
            end
            default: ;
         endcase
         if (r < 0) r = 0;
         else if (r > 255) r = 255;
         res[8*ch +: 8] = r[7:0];
      end
      return res;
   endfunction

   // ---------------------------------------------------------------- request driver
   always @(posedge clock) begin : drive_requests
      pixel_req_type done_px;
      if (reset) begin
         req_push <= 1'b0;
         in_hold = 0;
      end else begin
         if (req_push && !req_full) begin
            done_px = pending_pixels.pop_front();
            expected_colors.push_back(composite_pixel(model_cfg, done_px));
            pixels_sent++;
         end
         // hold the request steady while the block is full
         if (!(req_push && req_full)) begin
            if (in_hold > 0) begin
               in_hold--;
               req_push <= 1'b0;
            end else if (!calm && pending_pixels.size() != 0 &&
                         $urandom_range(0, 99) < in_gap_pct) begin
               in_hold = $urandom_range(1, 15) - 1;
               req_push <= 1'b0;
            end else if (pending_pixels.size() != 0) begin
               req_push         <= 1'b1;
               req_pixel_x      <= pending_pixels[0].x;
               req_line_y       <= pending_pixels[0].y;
               req_bg0_color    <= pending_pixels[0].bg0;
               req_bg1_color    <= pending_pixels[0].bg1;
               req_bg2_color    <= pending_pixels[0].bg2;
               req_bg3_color    <= pending_pixels[0].bg3;
               req_bg_present   <= pending_pixels[0].present;
               req_sprite_color <= pending_pixels[0].spr;
               req_sprite_flags <= pending_pixels[0].flags;
            end else begin
               req_push <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------- result monitor
   always @(posedge clock) begin : check_results
      logic [23:0] want;
      if (reset) begin
         rsp_pop <= 1'b0;
         out_hold = 0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            if (expected_colors.size() == 0) begin
               $display("%0t: unexpected result: expected none, actual out_color %06h",
                        $realtime, rsp_out_color);
               error_count++;
            end else begin
               want = expected_colors.pop_front();
               colors_checked++;
               if (rsp_out_color !== want) begin
                  $display("%0t: out_color mismatch: expected %06h, actual %06h",
                           $realtime, want, rsp_out_color);
                  error_count++;
               end
            end
         end
         if (out_hold > 0) begin
            out_hold--;
            rsp_pop <= 1'b0;
         end else if (!calm && $urandom_range(0, 99) < out_gap_pct) begin
            out_hold = $urandom_range(1, 15) - 1;
            rsp_pop <= 1'b0;
         end else begin
            rsp_pop <= 1'b1;
         end
      end
   end

   // ---------------------------------------------------------------- stimulus helpers
   // Called at a rising edge; leaves csr_valid high, the caller drops it.
   task automatic csr_write(input logic [CSR_INDEX_W-1:0] idx, input logic [63:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         CSR_WINDOW_RECTS:       model_cfg.window_rects = data;
         CSR_WINDOW_LAYER_MASKS: model_cfg.window_layer_masks = data[31:0];
         CSR_WINDOW_ENABLES:     model_cfg.window_enables = data[2:0];
         CSR_BLEND_SELECT:       model_cfg.blend_select = data[13:0];
         CSR_BLEND_COEFFS:       model_cfg.blend_coeffs = data[14:0];
         CSR_BG_PRIORITIES:      model_cfg.bg_priorities = data[7:0];
         CSR_BACKDROP_COLOR:     model_cfg.backdrop_color = data[14:0];
         default: ;
      endcase
   endtask

   task automatic load_config(input cfg_type c);
      csr_write(CSR_WINDOW_RECTS, c.window_rects);
      csr_write(CSR_WINDOW_LAYER_MASKS, 64'(c.window_layer_masks));
      csr_write(CSR_WINDOW_ENABLES, 64'(c.window_enables));
      csr_write(CSR_BLEND_SELECT, 64'(c.blend_select));
      csr_write(CSR_BLEND_COEFFS, 64'(c.blend_coeffs));
      csr_write(CSR_BG_PRIORITIES, 64'(c.bg_priorities));
      csr_write(CSR_BACKDROP_COLOR, 64'(c.backdrop_color));
      csr_valid <= 1'b0;
      settings_loaded++;
   endtask

   // Drain both sides, then give the pipeline a few more edges.
   task automatic wait_idle();
      while (pending_pixels.size() != 0 || expected_colors.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic put_pixel(input logic [7:0] x, input logic [7:0] y, input logic [23:0] b0,
                            input logic [23:0] b1, input logic [23:0] b2, input logic [23:0] b3,
                            input logic [3:0] pres, input logic [23:0] spr,
                            input logic [7:0] flags);
      pending_pixels.push_back('{x, y, b0, b1, b2, b3, pres, spr, flags});
   endtask

   // Channels lean toward 0 and 255 so saturation shows up often.
   function automatic logic [23:0] random_color();
      logic [23:0] c;
      for (int ch = 0; ch < 3; ch++) begin
         case ($urandom_range(0, 3))
            0:       c[8*ch +: 8] = 8'h00;
            1:       c[8*ch +: 8] = 8'hFF;
            default: c[8*ch +: 8] = 8'($urandom_range(0, 255));
         endcase
      end
      return c;
   endfunction

   function automatic pixel_req_type random_pixel();
      pixel_req_type px;
      px.x = 8'($urandom_range(0, 239));
      px.y = 8'($urandom_range(0, 159));
      px.bg0 = random_color();
      px.bg1 = random_color();
      px.bg2 = random_color();
      px.bg3 = random_color();
      px.present = 4'($urandom_range(0, 15));
      px.spr = random_color();
      px.flags = 8'($urandom_range(0, 255));
      return px;
   endfunction

   function automatic cfg_type random_cfg();
      cfg_type c;
      c.window_rects = {$urandom, $urandom};
      c.window_layer_masks = $urandom;
      c.window_enables = 3'($urandom_range(0, 7));
      c.blend_select = 14'($urandom_range(0, 16383));
      c.blend_coeffs = 15'($urandom_range(0, 32767));
      c.bg_priorities = 8'($urandom_range(0, 255));
      c.backdrop_color = 15'($urandom_range(0, 32767));
      return c;
   endfunction

   function automatic int gap_choice();
      case ($urandom_range(0, 3))
         0:       return 0;
         1:       return 5;
         2:       return 20;
         default: return 50;
      endcase
   endfunction

   // ---------------------------------------------------------------- test sequence
   initial begin : run_test
      cfg_type       dcfg;
      pixel_req_type px;
      logic [7:0]    edge_pos;
      int            k, idx;

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings: no windows, all priorities zero, no effect
      in_gap_pct = 20;
      out_gap_pct = 20;
      put_pixel(0, 0, 0, 0, 0, 0, 4'h0, 0, 8'h00);
      put_pixel(239, 159, 24'hFFFFFF, 24'h000000, 24'h123456, 24'hABCDEF, 4'hF,
                24'h555555, 8'h00);
      put_pixel(120, 80, 24'hFFFFFF, 24'h000000, 24'h123456, 24'hABCDEF, 4'hC,
                24'h555555, 8'h00);
      put_pixel(5, 5, 24'hFFFFFF, 24'h000000, 24'h123456, 24'hABCDEF, 4'hF,
                24'h00FF00, 8'h80);
      wait_idle();

      // alpha with full weights: saturates
      dcfg = '0;
      dcfg.backdrop_color = 15'h7FFF;
      dcfg.blend_select = 14'h3F7F;
      dcfg.blend_coeffs = 15'h7FFF;
      dcfg.bg_priorities = 8'hE4;
      load_config(dcfg);
      put_pixel(10, 10, 24'hFFFFFF, 24'h0, 24'h0, 24'h808080, 4'h9, 24'h0, 8'h00);
      put_pixel(10, 10, 24'h0, 24'h0, 24'h000000, 24'h0, 4'h4, 24'h0, 8'h00);
      put_pixel(10, 10, 24'h0, 24'h0, 24'h0, 24'h0, 4'h0, 24'h0, 8'h00);
      put_pixel(10, 10, 24'h0, 24'h0, 24'h0, 24'h0, 4'hF, 24'h0, 8'h87);
      wait_idle();

      // brighten, then darken past zero
      dcfg.blend_select = 14'h3FBF;
      load_config(dcfg);
      put_pixel(1, 1, 24'h000000, 24'h0, 24'h0, 24'h0, 4'h1, 24'h0, 8'h00);
      put_pixel(1, 1, 24'h7F3F01, 24'h0, 24'h0, 24'h0, 4'h1, 24'h0, 8'h00);
      wait_idle();
      dcfg.blend_select = 14'h3FFF;
      load_config(dcfg);
      put_pixel(2, 2, 24'hFFFFFF, 24'h0, 24'h0, 24'h0, 4'h1, 24'h0, 8'h00);
      put_pixel(2, 2, 24'h102030, 24'h0, 24'h0, 24'h0, 4'h1, 24'h0, 8'h00);
      wait_idle();

      // no first target selected; semi-transparent sprite still forces alpha
      dcfg.blend_select = 14'h3F40;
      load_config(dcfg);
      put_pixel(3, 3, 24'h336699, 24'h0, 24'h0, 24'h0, 4'h1, 24'h0, 8'h00);
      put_pixel(3, 3, 24'h336699, 24'h0, 24'h0, 24'h0, 4'h1, 24'h204060, 8'h81);
      wait_idle();

      // windows: horizontal wrap in window 0, vertical wrap in window 1, object window
      dcfg.window_enables = 3'b111;
      dcfg.window_rects = {16'h9614, 16'h3296, 16'h0A32, 16'hC828};
      dcfg.window_layer_masks = 32'h3004_0211;
      dcfg.blend_select = 14'h3FFF;
      dcfg.blend_coeffs = 15'h2186;
      load_config(dcfg);
      put_pixel(10, 20, 24'h111111, 24'h222222, 24'h333333, 24'h444444, 4'hF,
                24'hC0C0C0, 8'h00);
      put_pixel(239, 49, 24'h111111, 24'h222222, 24'h333333, 24'h444444, 4'hF,
                24'hC0C0C0, 8'h00);
      put_pixel(100, 155, 24'h111111, 24'h222222, 24'h333333, 24'h444444, 4'hF,
                24'hC0C0C0, 8'h00);
      put_pixel(100, 100, 24'h111111, 24'h222222, 24'h333333, 24'h444444, 4'hF,
                24'hC0C0C0, 8'hC0);
      put_pixel(100, 100, 24'h111111, 24'h222222, 24'h333333, 24'h444444, 4'hF,
                24'hC0C0C0, 8'h81);
      put_pixel(10, 20, 24'h111111, 24'h222222, 24'h333333, 24'h444444, 4'hF,
                24'hC0C0C0, 8'h81);
      put_pixel(40, 20, 24'h111111, 24'h222222, 24'h333333, 24'h444444, 4'hF,
                24'hC0C0C0, 8'h00);
      wait_idle();

      // random phases: all-ones first, all-zero last, no stalls at the end
      for (int ph = 0; ph < 34; ph++) begin
         if (ph == 0) dcfg = '1;
         else if (ph == 33) dcfg = '0;
         else dcfg = random_cfg();
         load_config(dcfg);
         calm = (ph >= 31);
         in_gap_pct = gap_choice();
         out_gap_pct = gap_choice();
         for (int n = 0; n < 50; n++) begin
            px = random_pixel();
            // land on a window edge now and then
            if ($urandom_range(0, 3) == 0) begin
               k = $urandom_range(0, 3);
               idx = (k >> 1) * 4 + (k & 1);
               edge_pos = model_cfg.window_rects[8*idx +: 8];
               if (edge_pos <= 8'd239) px.x = edge_pos;
               edge_pos = model_cfg.window_rects[8*(idx+2) +: 8];
               if (edge_pos <= 8'd159) px.y = edge_pos;
            end
            pending_pixels.push_back(px);
         end
         wait_idle();
      end

      repeat (10) @(posedge clock);
      $display("Checked %0d of %0d pixels across %0d register settings.",
               colors_checked, pixels_sent, settings_loaded);
      $display("Mix: wrapped and empty windows, sprite ties, all blend modes, random stalls.");
      if (error_count == 0 && expected_colors.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   initial begin : watchdog
      #1_000_000;
      $display("Simulation FAILED");
      $finish;
   end

endmodule
